FILE: sv/olt_pkg.sv
// Package for the mesh-text line-kind counter.
// Holds the parser mode type, status codes, widths and helper functions.
// Depends on nothing.
package olt_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int TOTAL_WIDTH = 24;
	localparam int CLAMP_WIDTH = (COUNT_WIDTH > TOTAL_WIDTH) ? COUNT_WIDTH : TOTAL_WIDTH;

	localparam logic [7:0] CHAR_F       = 8'h66;
	localparam logic [7:0] CHAR_V       = 8'h76;
	localparam logic [7:0] CHAR_T       = 8'h74;
	localparam logic [7:0] CHAR_N       = 8'h6e;
	localparam logic [7:0] CHAR_P       = 8'h70;
	localparam logic [7:0] CHAR_HASH    = 8'h23;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NUL     = 8'h00;
	localparam logic [7:0] CHAR_LF      = 8'h0a;
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_CR      = 8'h0d;
	localparam logic [1:0] MIN_VERTICES = 2'd2;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [TOTAL_WIDTH-1:0] total_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_VERT  = 2'd1,
		STATUS_FEW_VERT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		MODE_START    = 4'd0,
		MODE_AFTER_F  = 4'd1,
		MODE_AFTER_P  = 4'd2,
		MODE_AFTER_V  = 4'd3,
		MODE_AFTER_VT = 4'd4,
		MODE_AFTER_VN = 4'd5,
		MODE_BODY     = 4'd6,
		MODE_GAP      = 4'd7,
		MODE_COMMENT  = 4'd8,
		MODE_ENDED    = 4'd9
	} mode_t;

	function automatic count_t bump(input count_t c);
		return (c == {COUNT_WIDTH{1'b1}}) ? c : c + count_t'(1);
	endfunction

	function automatic total_t clamp_total(input count_t c);
		logic [CLAMP_WIDTH-1:0] wide;
		logic [CLAMP_WIDTH-1:0] lim;
		wide = CLAMP_WIDTH'(c);
		lim  = CLAMP_WIDTH'({TOTAL_WIDTH{1'b1}});
		return (wide > lim) ? {TOTAL_WIDTH{1'b1}} : TOTAL_WIDTH'(wide);
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
	endfunction

	function automatic mode_t line_first(input logic [7:0] b);
		if (b == CHAR_NUL) return MODE_ENDED;
		if (b == CHAR_F) return MODE_AFTER_F;
		if (b == CHAR_P) return MODE_AFTER_P;
		if (b == CHAR_V) return MODE_AFTER_V;
		return MODE_BODY;
	endfunction

	function automatic mode_t body_next(input logic [7:0] b);
		if (b == CHAR_NUL) return MODE_ENDED;
		if (b == CHAR_LF) return MODE_GAP;
		return MODE_BODY;
	endfunction

endpackage

FILE: sv/obj_line_type_counter.sv
// Top level of the mesh-text line-kind counter.
// Registers each request, updates the parser mode and the five line counters,
// and holds the result in an output register. Depends on olt_pkg.
//
// Usage: the text enters one byte per request on the input channel
// (in_valid, in_stall, data_byte, last_byte). Every byte is taken by an
// input register; from there it updates the parser mode and the
// vertex, texcoord, normal, face and point counters. Only the byte marked
// last produces a request on the output channel (out_valid, out_stall and
// the six result fields): its counts and status are loaded into the output
// register when it leaves the input register, and the parser then returns
// to its reset state so the next file may follow at once. Throughput is one
// byte per cycle while no last-marked byte is held, set by the single mode
// update between the input register and the result register. While a
// result waits under out_stall, bytes that produce no result keep flowing;
// only a further last-marked byte holds in the input register, and in_stall
// rises until the waiting result is taken. Reset puts the parser at the start
// of a line, clears all counters and empties both registers.
module obj_line_type_counter
	import olt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   data_byte,
	input  logic         last_byte,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [23:0]  vertex_total,
	output logic [23:0]  texcoord_total,
	output logic [23:0]  normal_total,
	output logic [23:0]  face_total,
	output logic [23:0]  point_total,
	output logic [1:0]   check_status
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	mode_t       mode_q;
	mode_t       mode_next;
	count_t      vertex_q, texcoord_q, normal_q, face_q, point_q;
	count_t      vertex_n, texcoord_n, normal_n, face_n, point_n;

	logic        out_valid_q;
	total_t      vertex_total_q, texcoord_total_q, normal_total_q;
	total_t      face_total_q, point_total_q;
	status_t     status_q;
	status_t     status_n;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (in_valid && !in_stall) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		mode_next  = mode_q;
		vertex_n   = vertex_q;
		texcoord_n = texcoord_q;
		normal_n   = normal_q;
		face_n     = face_q;
		point_n    = point_q;
		unique case (mode_q)
			MODE_START: begin
				mode_next = line_first(byte_s1);
			end
			MODE_AFTER_F: begin
				if (byte_s1 == CHAR_SPACE) begin
					face_n    = bump(face_q);
					mode_next = MODE_BODY;
				end else begin
					mode_next = body_next(byte_s1);
				end
			end
			MODE_AFTER_P: begin
				if (byte_s1 == CHAR_SPACE) begin
					point_n   = bump(point_q);
					mode_next = MODE_BODY;
				end else begin
					mode_next = body_next(byte_s1);
				end
			end
			MODE_AFTER_V: begin
				if (byte_s1 == CHAR_SPACE) begin
					vertex_n  = bump(vertex_q);
					mode_next = MODE_BODY;
				end else if (byte_s1 == CHAR_T) begin
					mode_next = MODE_AFTER_VT;
				end else if (byte_s1 == CHAR_N) begin
					mode_next = MODE_AFTER_VN;
				end else begin
					mode_next = body_next(byte_s1);
				end
			end
			MODE_AFTER_VT: begin
				if (byte_s1 == CHAR_SPACE) begin
					texcoord_n = bump(texcoord_q);
					mode_next  = MODE_BODY;
				end else begin
					mode_next = body_next(byte_s1);
				end
			end
			MODE_AFTER_VN: begin
				if (byte_s1 == CHAR_SPACE) begin
					normal_n  = bump(normal_q);
					mode_next = MODE_BODY;
				end else begin
					mode_next = body_next(byte_s1);
				end
			end
			MODE_BODY: begin
				mode_next = body_next(byte_s1);
			end
			MODE_GAP: begin
				if (byte_s1 == CHAR_NUL) begin
					mode_next = MODE_ENDED;
				end else if (is_space(byte_s1)) begin
					mode_next = MODE_GAP;
				end else if (byte_s1 == CHAR_HASH) begin
					mode_next = MODE_COMMENT;
				end else begin
					mode_next = line_first(byte_s1);
				end
			end
			MODE_COMMENT: begin
				if (byte_s1 == CHAR_NUL) begin
					mode_next = MODE_ENDED;
				end else if (byte_s1 == CHAR_LF) begin
					mode_next = MODE_GAP;
				end else begin
					mode_next = MODE_COMMENT;
				end
			end
			default: begin
				mode_next = MODE_ENDED;
			end
		endcase
	end

	always_comb begin
		if (vertex_n == '0) begin
			status_n = STATUS_NO_VERT;
		end else if ((vertex_n < COUNT_WIDTH'(MIN_VERTICES)) && (face_n != '0)) begin
			status_n = STATUS_FEW_VERT;
		end else begin
			status_n = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_START;
			vertex_q   <= '0;
			texcoord_q <= '0;
			normal_q   <= '0;
			face_q     <= '0;
			point_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				mode_q     <= MODE_START;
				vertex_q   <= '0;
				texcoord_q <= '0;
				normal_q   <= '0;
				face_q     <= '0;
				point_q    <= '0;
			end else begin
				mode_q     <= mode_next;
				vertex_q   <= vertex_n;
				texcoord_q <= texcoord_n;
				normal_q   <= normal_n;
				face_q     <= face_n;
				point_q    <= point_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			vertex_total_q   <= clamp_total(vertex_n);
			texcoord_total_q <= clamp_total(texcoord_n);
			normal_total_q   <= clamp_total(normal_n);
			face_total_q     <= clamp_total(face_n);
			point_total_q    <= clamp_total(point_n);
			status_q         <= status_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign vertex_total   = vertex_total_q;
	assign texcoord_total = texcoord_total_q;
	assign normal_total   = normal_total_q;
	assign face_total     = face_total_q;
	assign point_total    = point_total_q;
	assign check_status   = status_q;

`ifndef SYNTH
	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> mode_q == MODE_START && vertex_q == '0 && face_q == '0)
		else $error("Parser did not return to line start after the last byte.");

	a_hold_last_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_valid_q && out_stall |-> in_stall)
		else $error("A last byte advanced while the result register was blocked.");

	a_ok_has_vertices: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == STATUS_OK |-> vertex_total_q != '0)
		else $error("Status ok with a vertex count of zero.");

	a_ended_counts_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !last_s1 && mode_q == MODE_ENDED |=>
			$stable(vertex_q) && $stable(face_q) && mode_q == MODE_ENDED)
		else $error("Counts or mode changed after the end of text.");
`endif

endmodule
